### hdl/vtx4_pkg.sv
// ----------------------------------------------------------------------------
// vtx4_pkg
// Shared widths, types and reset constants for the 4x4 vector transform.
// ----------------------------------------------------------------------------
package vtx4_pkg;

  // Vector and matrix shape
  localparam int NumComp  = 4;
  localparam int NumCoef  = NumComp * NumComp;
  localparam int NumRegs  = NumCoef / 2;

  // Data widths: Q16.16 operands, Q32.32 products, exact sum of four products
  localparam int CompW    = 32;
  localparam int PairW    = 2 * CompW;
  localparam int ProdW    = 2 * CompW;
  localparam int SumW     = ProdW + 2;
  localparam int FracDrop = 16;

  // Configuration index width (indexes beyond the register list are ignored)
  localparam int CfgIdxW  = 4;

  // Half an output LSB in Q32.32, for round half up
  localparam logic [SumW-1:0] HalfLsb = SumW'(64'h0000_0000_0000_8000);

  // Saturation limits in Q16.16
  localparam logic [CompW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [CompW-1:0] SatNeg = 32'h8000_0000;

  // Coefficient register reset: identity matrix
  localparam logic [PairW-1:0] CoefPairReset [NumRegs] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  // Product ordering mode
  typedef enum logic {
    MODE_COL_MAJOR = 1'b0,
    MODE_ROW_MAJOR = 1'b1
  } mode_t;

endpackage

### hdl/vtx4_if.sv
// ----------------------------------------------------------------------------
// vtx4 channel interfaces
// Valid/ready channels for input vectors, results and coefficient writes.
// ----------------------------------------------------------------------------

// Input vector channel
interface vtx4_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [vtx4_pkg::CompW-1:0] in_x;
  logic [vtx4_pkg::CompW-1:0] in_y;
  logic [vtx4_pkg::CompW-1:0] in_z;
  logic [vtx4_pkg::CompW-1:0] in_w;

  modport source (output valid, mode, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, mode, in_x, in_y, in_z, in_w, output ready);
endinterface

// Result channel
interface vtx4_out_if;
  logic                       valid;
  logic                       ready;
  logic [vtx4_pkg::CompW-1:0] out_x;
  logic [vtx4_pkg::CompW-1:0] out_y;
  logic [vtx4_pkg::CompW-1:0] out_z;
  logic [vtx4_pkg::CompW-1:0] out_w;
  logic                       overflow;

  modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

// Coefficient write channel
interface vtx4_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [vtx4_pkg::CfgIdxW-1:0] index;
  logic [vtx4_pkg::PairW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/vector_transform_4x4_core.sv
// ----------------------------------------------------------------------------
// vector_transform_4x4_core
// Streams 4-component Q16.16 vectors through a configured 4x4 matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one word per vector (mode, in_x..in_w), taken when valid and
//              ready are both high. mode 0 gives the column-major product,
//              mode 1 the row-major product.
//   out_chan : one word per vector (out_x..out_w, overflow), in input order.
//   cfg_chan : writes one 64-bit coefficient pair per word; always ready.
//              Indexes beyond the eight pairs are dropped. Write only while
//              no vectors are in flight.
// Registered stages, in order: operand select, multiply, pair sums, lane
// total, round and saturate. Throughput is one vector per cycle while results
// are taken, set by the sixteen parallel 32x32 multipliers.
// Reset clears the valid bit of every pipeline stage and loads the identity matrix.
// When the receiver stalls, the result waits in the output register and
// upstream stages keep filling their empty slots; ready drops only once
// every stage holds a word.
// ----------------------------------------------------------------------------
module vector_transform_4x4_core (
  input  logic        clk,
  input  logic        rst_n,
  vtx4_in_if.sink     in_chan,
  vtx4_out_if.source  out_chan,
  vtx4_cfg_if.sink    cfg_chan
);
  import vtx4_pkg::*;

  logic [CompW-1:0] coef [NumCoef];
  logic [CompW-1:0] comp [NumComp];
  logic [ProdW-1:0] prod [NumComp][NumComp];
  logic [CompW-1:0] res [NumComp];
  logic             mul_valid;
  logic             sum_ready;

  assign comp[0] = in_chan.in_x;
  assign comp[1] = in_chan.in_y;
  assign comp[2] = in_chan.in_z;
  assign comp[3] = in_chan.in_w;

  // Coefficient storage
  vtx4_coef_regs u_coef_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .coef     (coef)
  );

  // Select and multiply
  vtx4_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_chan.valid),
    .ready_o (in_chan.ready),
    .mode    (in_chan.mode),
    .comp    (comp),
    .coef    (coef),
    .valid_o (mul_valid),
    .ready_i (sum_ready),
    .prod    (prod)
  );

  // Sum, round and saturate
  vtx4_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (mul_valid),
    .ready_o  (sum_ready),
    .prod     (prod),
    .valid_o  (out_chan.valid),
    .ready_i  (out_chan.ready),
    .res      (res),
    .overflow (out_chan.overflow)
  );

  assign out_chan.out_x = res[0];
  assign out_chan.out_y = res[1];
  assign out_chan.out_z = res[2];
  assign out_chan.out_w = res[3];

endmodule

### hdl/vtx4_coef_regs.sv
// ----------------------------------------------------------------------------
// vtx4_coef_regs
// Coefficient register file: eight 64-bit pairs, presented as 16 entries.
// ----------------------------------------------------------------------------
module vtx4_coef_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  vtx4_cfg_if.sink                   cfg_chan,
  output logic [vtx4_pkg::CompW-1:0] coef [vtx4_pkg::NumCoef]
);
  import vtx4_pkg::*;

  logic [PairW-1:0] pair_r [NumRegs];

  // Writes always complete; an index beyond the list matches no register
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NumRegs; r++) begin
        pair_r[r] <= CoefPairReset[r];
      end
    end else if (cfg_chan.valid) begin
      for (int r = 0; r < NumRegs; r++) begin
        if (cfg_chan.index == CfgIdxW'(r)) begin
          pair_r[r] <= cfg_chan.data;
        end
      end
    end
  end

  // Even entry in the low half, odd entry in the high half
  always_comb begin
    for (int k = 0; k < NumCoef; k++) begin
      coef[k] = pair_r[k / 2][(k % 2) * CompW +: CompW];
    end
  end

endmodule

### hdl/vtx4_mul.sv
// ----------------------------------------------------------------------------
// vtx4_mul
// Operand select stage and 16-way signed 32x32 multiply stage.
// ----------------------------------------------------------------------------
module vtx4_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  // upstream
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       mode,
  input  logic [vtx4_pkg::CompW-1:0] comp [vtx4_pkg::NumComp],
  input  logic [vtx4_pkg::CompW-1:0] coef [vtx4_pkg::NumCoef],
  // downstream
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [vtx4_pkg::ProdW-1:0] prod [vtx4_pkg::NumComp][vtx4_pkg::NumComp]
);
  import vtx4_pkg::*;

  logic             v1_r;
  logic             v2_r;
  logic             adv1;
  logic             adv2;
  logic [CompW-1:0] comp_r [NumComp];
  logic [CompW-1:0] sel_nxt [NumComp][NumComp];
  logic [CompW-1:0] sel_r [NumComp][NumComp];
  logic [ProdW-1:0] prod_nxt [NumComp][NumComp];
  logic [ProdW-1:0] prod_r [NumComp][NumComp];

  // Stage advance: a stage takes a word when empty or when it drains
  assign adv2    = !v2_r || ready_i;
  assign adv1    = !v1_r || adv2;
  assign ready_o = adv1;
  assign valid_o = v2_r;
  assign prod    = prod_r;

  // Coefficient for lane i, term j
  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      for (int j = 0; j < NumComp; j++) begin
        if (mode_t'(mode) == MODE_ROW_MAJOR) begin
          sel_nxt[i][j] = coef[NumComp * i + j];
        end else begin
          sel_nxt[i][j] = coef[i + NumComp * j];
        end
      end
    end
  end

  // Exact Q32.32 products
  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      for (int j = 0; j < NumComp; j++) begin
        prod_nxt[i][j] = ProdW'($signed(sel_r[i][j])) * ProdW'($signed(comp_r[j]));
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= valid_i;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv1 && valid_i) begin
      comp_r <= comp;
      sel_r  <= sel_nxt;
    end
    if (adv2 && v1_r) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### hdl/vtx4_sum.sv
// ----------------------------------------------------------------------------
// vtx4_sum
// Pairwise sums with rounding offset, lane total, and saturation to Q16.16.
// ----------------------------------------------------------------------------
module vtx4_sum (
  input  logic                       clk,
  input  logic                       rst_n,
  // upstream
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [vtx4_pkg::ProdW-1:0] prod [vtx4_pkg::NumComp][vtx4_pkg::NumComp],
  // downstream
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [vtx4_pkg::CompW-1:0] res [vtx4_pkg::NumComp],
  output logic                       overflow
);
  import vtx4_pkg::*;

  // The kept field's sign bit and all bits above it must match for no saturation
  localparam int TopLo = FracDrop + CompW - 1;

  logic            v3_r;
  logic            v4_r;
  logic            v5_r;
  logic            adv3;
  logic            adv4;
  logic            adv5;
  logic [SumW-1:0] s01_nxt [NumComp];
  logic [SumW-1:0] s23_nxt [NumComp];
  logic [SumW-1:0] s01_r [NumComp];
  logic [SumW-1:0] s23_r [NumComp];
  logic [SumW-1:0] tot_nxt [NumComp];
  logic [SumW-1:0] tot_r [NumComp];
  logic [CompW-1:0] res_nxt [NumComp];
  logic [CompW-1:0] res_r [NumComp];
  logic            ovf_nxt;
  logic            ovf_r;

  assign adv5     = !v5_r || ready_i;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign ready_o  = adv3;
  assign valid_o  = v5_r;
  assign res      = res_r;
  assign overflow = ovf_r;

  // Pair sums; the half LSB rides along with the first pair
  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      s01_nxt[i] = SumW'($signed(prod[i][0])) + SumW'($signed(prod[i][1])) + HalfLsb;
      s23_nxt[i] = SumW'($signed(prod[i][2])) + SumW'($signed(prod[i][3]));
    end
  end

  // Lane total, already offset for round half up
  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      tot_nxt[i] = s01_r[i] + s23_r[i];
    end
  end

  // Drop the low fraction bits and clamp to signed 32 bits
  always_comb begin
    ovf_nxt = 1'b0;
    for (int i = 0; i < NumComp; i++) begin
      if (&tot_r[i][SumW-1:TopLo] || !(|tot_r[i][SumW-1:TopLo])) begin
        res_nxt[i] = tot_r[i][FracDrop +: CompW];
      end else begin
        ovf_nxt = 1'b1;
        if (tot_r[i][SumW-1]) begin
          res_nxt[i] = SatNeg;
        end else begin
          res_nxt[i] = SatPos;
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv3) begin
        v3_r <= valid_i;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
      if (adv5) begin
        v5_r <= v4_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv3 && valid_i) begin
      s01_r <= s01_nxt;
      s23_r <= s23_nxt;
    end
    if (adv4 && v3_r) begin
      tot_r <= tot_nxt;
    end
    if (adv5 && v4_r) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

### tb/vector_transform_4x4_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_transform_4x4_core_test
// Self-checking bench for the 4x4 matrix-vector transform. Every vector word
// accepted on the input channel is run through a bit-exact predictor with its
// own copy of the coefficient pairs. Each result word is compared lane by
// lane against the oldest prediction. Directed words cover reset identity,
// mode ordering, saturation in both directions and round-half-up ties.
// Random phases then vary the matrix, the operands and the handshake
// pressure on both sides.
// ----------------------------------------------------------------------------
module vector_transform_4x4_core_test;
  import vtx4_pkg::*;

  typedef logic [NumComp-1:0][CompW-1:0] quad_t;

  typedef struct packed {
    quad_t comp;
    logic  ovf;
  } result_word_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_t;
  typedef enum {MAT_SMALL, MAT_FULL, MAT_MIXED, MAT_ZERO, MAT_ONES} mat_kind_t;

  // Rounded Q32.32 sums at or above 2^47, or below -2^47, leave the Q16.16 range
  localparam logic signed [SumW-1:0] RoundTop = SumW'(1) <<< (CompW + FracDrop - 1);

  localparam int HoldCycles = 80;
  localparam int PhaseWords = 225;
  localparam int NumPhases  = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: coefficient shadow, predictor and queue of predicted words
  // --------------------------------------------------------------------------
  class xform_scoreboard;
    logic [PairW-1:0] coef [NumRegs];
    result_word_t     predicted [$];
    string            lane_name [NumComp] = '{"out_x", "out_y", "out_z", "out_w"};
    int               errors;
    int               vectors;
    int               checked;
    int               saturated;

    function new();
      foreach (coef[n]) coef[n] = CoefPairReset[n];
      errors    = 0;
      vectors   = 0;
      checked   = 0;
      saturated = 0;
    endfunction

    // out-of-range indexes are dropped by the block
    function void write_pair(logic [CfgIdxW-1:0] idx, logic [PairW-1:0] val);
      if (idx < NumRegs) coef[idx] = val;
    endfunction

    function logic signed [CompW-1:0] coef_entry(int k);
      logic [PairW-1:0] pair;
      pair = coef[k / 2];
      return (k % 2) ? pair[PairW-1:CompW] : pair[CompW-1:0];
    endfunction

    // exact sum of four Q32.32 products, round half up, saturate
    function result_word_t transform(mode_t m, quad_t v);
      result_word_t           r;
      logic signed [SumW-1:0]  acc;
      logic signed [ProdW-1:0] prod;
      int                      k;
      r.ovf = 1'b0;
      for (int i = 0; i < NumComp; i++) begin
        acc = '0;
        for (int j = 0; j < NumComp; j++) begin
          k    = (m == MODE_ROW_MAJOR) ? NumComp * i + j : i + NumComp * j;
          prod = coef_entry(k) * $signed(v[j]);
          acc  = acc + prod;
        end
        acc = acc + $signed(HalfLsb);
        if (acc >= RoundTop) begin
          r.comp[i] = SatPos;
          r.ovf     = 1'b1;
        end else if (acc < -RoundTop) begin
          r.comp[i] = SatNeg;
          r.ovf     = 1'b1;
        end else begin
          r.comp[i] = acc[FracDrop +: CompW];
        end
      end
      return r;
    endfunction

    function void note_vector(mode_t m, quad_t v);
      predicted.push_back(transform(m, v));
      vectors++;
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (predicted.size() == 0) begin
        $display("%0t: result word with nothing predicted: %h", $time, got);
        errors++;
        return;
      end
      want = predicted.pop_front();
      checked++;
      if (want.ovf) saturated++;
      for (int i = 0; i < NumComp; i++) begin
        if (got.comp[i] !== want.comp[i]) begin
          $display("%0t: %s expected %h actual %h", $time, lane_name[i],
                   want.comp[i], got.comp[i]);
          errors++;
        end
      end
      if (got.ovf !== want.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, DUT
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  vtx4_in_if  in_chan ();
  vtx4_out_if out_chan ();
  vtx4_cfg_if cfg_chan ();

  vector_transform_4x4_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  xform_scoreboard sb;
  idle_phase_t     idle_phase;
  logic [CompW-1:0] mat_ent [NumCoef];
  int              hold_req;
  int              hold_left;
  int              cfg_writes;
  int              cfg_loads;
  result_word_t    seen_word;

  idle_phase_t plan_idle [NumPhases] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                         IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
  mat_kind_t   plan_mat  [NumPhases] = '{MAT_SMALL, MAT_FULL, MAT_MIXED, MAT_SMALL,
                                         MAT_ZERO, MAT_SMALL, MAT_ONES, MAT_FULL};

  // --------------------------------------------------------------------------
  // Idling rates per phase
  // --------------------------------------------------------------------------
  function automatic int sender_idle_pct();
    case (idle_phase)
      IDLE_SENDER: return 63;
      IDLE_BOTH:   return 6;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_phase)
      IDLE_RECEIVER: return 63;
      IDLE_BOTH:     return 6;
      default:       return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Operand and matrix generation
  // --------------------------------------------------------------------------
  function automatic quad_t quad(logic [CompW-1:0] x, logic [CompW-1:0] y,
                                 logic [CompW-1:0] z, logic [CompW-1:0] w);
    quad_t q;
    q[0] = x;
    q[1] = y;
    q[2] = z;
    q[3] = w;
    return q;
  endfunction

  function automatic logic [CompW-1:0] pick_extreme();
    case ($urandom_range(5))
      0:       return SatPos;
      1:       return SatNeg;
      2:       return '0;
      3:       return 32'h0000_0001;
      4:       return '1;
      default: return 32'h0000_8000;
    endcase
  endfunction

  // half small values (+/- 16.0), some full range, some extremes
  function automatic logic [CompW-1:0] rand_comp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return CompW'($urandom_range(32'h0020_0000) - 32'h0010_0000);
    if (pick < 80) return $urandom;
    return pick_extreme();
  endfunction

  task automatic fill_matrix(input mat_kind_t kind);
    foreach (mat_ent[k]) begin
      case (kind)
        MAT_SMALL: mat_ent[k] = CompW'($urandom_range(32'h0008_0000) - 32'h0004_0000);
        MAT_FULL:  mat_ent[k] = $urandom;
        MAT_MIXED: begin
          case ($urandom_range(5))
            0:       mat_ent[k] = SatPos;
            1:       mat_ent[k] = SatNeg;
            2:       mat_ent[k] = '0;
            3:       mat_ent[k] = 32'h0001_0000;
            4:       mat_ent[k] = 32'hFFFF_0000;
            default: mat_ent[k] = 32'h0000_8000;
          endcase
        end
        MAT_ZERO:  mat_ent[k] = '0;
        default:   mat_ent[k] = '1;
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_vector(input mode_t m, input quad_t v);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct()) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.mode  = m;
    in_chan.in_x  = v[0];
    in_chan.in_y  = v[1];
    in_chan.in_z  = v[2];
    in_chan.in_w  = v[3];
    do @(posedge clk); while (!in_chan.ready);
    sb.note_vector(m, v);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (sb.predicted.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Coefficient writes, only with the pipeline empty
  // --------------------------------------------------------------------------
  task automatic write_pair(input logic [CfgIdxW-1:0] idx, input logic [PairW-1:0] val);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = val;
    do @(posedge clk); while (!cfg_chan.ready);
    sb.write_pair(idx, val);
    cfg_writes++;
  endtask

  task automatic load_matrix();
    wait_drained();
    for (int n = 0; n < NumRegs; n++) begin
      write_pair(CfgIdxW'(n), {mat_ent[2*n+1], mat_ent[2*n]});
      // stray write past the register list must leave the matrix alone
      if (n == 3) write_pair(CfgIdxW'(NumRegs + $urandom_range(NumRegs - 1)),
                             {$urandom, $urandom});
    end
    @(negedge clk);
    cfg_chan.valid = 1'b0;
    cfg_loads++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver ready, with one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    hold_left      = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = HoldCycles;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else begin
        out_chan.ready = ($urandom_range(99) >= receiver_stall_pct());
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_word.comp[0] = out_chan.out_x;
      seen_word.comp[1] = out_chan.out_y;
      seen_word.comp[2] = out_chan.out_z;
      seen_word.comp[3] = out_chan.out_w;
      seen_word.ovf     = out_chan.overflow;
      sb.check_result(seen_word);
    end
  end

  // Watchdog
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.mode   = 1'b0;
    in_chan.in_x   = '0;
    in_chan.in_y   = '0;
    in_chan.in_z   = '0;
    in_chan.in_w   = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data  = '0;
    idle_phase     = IDLE_NONE;
    hold_req       = 0;
    cfg_writes     = 0;
    cfg_loads      = 0;
    sb             = new();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // identity matrix straight out of reset
    send_vector(MODE_COL_MAJOR, quad(SatPos, SatNeg, '0, 32'h0000_0001));
    send_vector(MODE_ROW_MAJOR, quad(SatPos, SatNeg, '0, 32'h0000_0001));
    send_vector(MODE_COL_MAJOR, quad('1, 32'h0000_8000, 32'h7FFF_0000, 32'h1234_5678));
    send_vector(MODE_ROW_MAJOR, quad('1, 32'h0000_8000, 32'h7FFF_0000, 32'h1234_5678));

    // asymmetric matrix separates the two orderings
    foreach (mat_ent[k]) mat_ent[k] = CompW'((k - 7) <<< FracDrop);
    load_matrix();
    send_vector(MODE_COL_MAJOR, quad(32'h0001_0000, 32'h0002_0000,
                                     32'h0003_0000, 32'h0004_0000));
    send_vector(MODE_ROW_MAJOR, quad(32'h0001_0000, 32'h0002_0000,
                                     32'h0003_0000, 32'h0004_0000));
    send_vector(MODE_COL_MAJOR, quad(32'h0000_4000, 32'hFFFF_C000,
                                     32'h0002_8000, 32'h0000_0001));

    // largest entries: positive and negative saturation, cancelling lanes
    foreach (mat_ent[k]) mat_ent[k] = SatPos;
    load_matrix();
    send_vector(MODE_COL_MAJOR, quad(SatPos, SatPos, SatPos, SatPos));
    send_vector(MODE_COL_MAJOR, quad(SatNeg, SatNeg, SatNeg, SatNeg));
    send_vector(MODE_ROW_MAJOR, quad(SatPos, SatNeg, SatPos, SatNeg));

    // most negative entries: largest possible sum
    foreach (mat_ent[k]) mat_ent[k] = SatNeg;
    load_matrix();
    send_vector(MODE_COL_MAJOR, quad(SatNeg, SatNeg, SatNeg, SatNeg));
    send_vector(MODE_ROW_MAJOR, quad(SatPos, SatPos, SatPos, SatPos));

    // entries of 0.5 against odd LSBs land exactly halfway
    foreach (mat_ent[k]) mat_ent[k] = 32'h0000_8000;
    load_matrix();
    send_vector(MODE_COL_MAJOR, quad(32'h0000_0001, '0, '0, '0));
    send_vector(MODE_COL_MAJOR, quad('1, '0, '0, '0));
    send_vector(MODE_ROW_MAJOR, quad(32'h0000_0003, '0, '0, '0));
    send_vector(MODE_ROW_MAJOR, quad(32'hFFFF_FFFD, '0, '0, '0));

    // random phases
    for (int p = 0; p < NumPhases; p++) begin
      fill_matrix(plan_mat[p]);
      load_matrix();
      idle_phase = plan_idle[p];
      // long receiver hold-off while the sender keeps offering words
      if (p == 0) hold_req = 1;
      for (int n = 0; n < PhaseWords; n++)
        send_vector(mode_t'($urandom_range(1)),
                    quad(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.predicted.size() != 0) sb.errors++;

    $display("Sent %0d vectors and checked %0d result words (%0d saturating),",
             sb.vectors, sb.checked, sb.saturated);
    $display("over %0d matrix loads (%0d coefficient writes) and four idling patterns.",
             cfg_loads, cfg_writes);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/vtx4_pkg.sv
hdl/vtx4_if.sv
hdl/vtx4_coef_regs.sv
hdl/vtx4_mul.sv
hdl/vtx4_sum.sv
hdl/vector_transform_4x4_core.sv
tb/vector_transform_4x4_core_test.sv
